// ----- src/owbm_pkg.sv -----
// ----------------------------------------------------------------------------
// owbm_pkg - shared types and constants for the 1-wire bus master
// Operation codes, command modes, register indexes, timing and result types.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int BITS_PER_TRANSFER = 8;
  localparam int TIMER_BITS        = 16;
  localparam int CFG_BITS          = 16;
  localparam int CFG_INDEX_BITS    = 3;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_BITS-1:0]   cfg_word_t;

  // command modes carried in tuser
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_RESET_LOW  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RESET_WAIT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_PULSE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLOT       = 3'd5;

  localparam cfg_word_t RST_RESET_LOW  = 16'd500;
  localparam cfg_word_t RST_RESET_WAIT = 16'd500;
  localparam cfg_word_t RST_START      = 16'd2;
  localparam cfg_word_t RST_LOW_PULSE  = 16'd3;
  localparam cfg_word_t RST_SAMPLE     = 16'd4;
  localparam cfg_word_t RST_SLOT       = 16'd80;

  typedef struct packed {
    cfg_word_t reset_low_time;
    cfg_word_t reset_wait_time;
    cfg_word_t start_delay;
    cfg_word_t low_pulse_time;
    cfg_word_t sample_delay;
    cfg_word_t slot_time;
  } timing_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       busy_res;
    logic       line_release;
  } res_t;

  // register value to timer load; zero loads as one
  function automatic timer_t timer_load(input cfg_word_t v);
    timer_t t;
    t = timer_t'(v);
    if (t == '0) t = timer_t'(1);
    return t;
  endfunction

endpackage

// ----- src/owbm_seq.sv -----
// ----------------------------------------------------------------------------
// owbm_seq - phase sequencer of the 1-wire bus master
// Holds operation state; one beat updates it in a single pass.
// ----------------------------------------------------------------------------
module owbm_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [1:0]      mode,
  input  logic [7:0]      write_byte,
  input  logic            line_sample,
  input  owbm_pkg::timing_t timing,
  output owbm_pkg::res_t  result
);
  import owbm_pkg::*;

  logic       busy_flag,     busy_flag_next;
  op_t        operation,     operation_next;
  logic [1:0] phase,         phase_next;
  logic [3:0] bit_count,     bit_count_next;
  logic [7:0] send_byte,     send_byte_next;
  logic [7:0] received_byte, received_byte_next;
  timer_t     countdown,     countdown_next;
  logic       line_level,    line_level_next;

  always_comb begin
    busy_flag_next     = busy_flag;
    operation_next     = operation;
    phase_next         = phase;
    bit_count_next     = bit_count;
    send_byte_next     = send_byte;
    received_byte_next = received_byte;
    countdown_next     = countdown;
    line_level_next    = line_level;

    if (mode == MODE_TICK) begin
      if (busy_flag && countdown != '0) begin
        countdown_next = countdown - timer_t'(1);
        if (countdown_next == '0) begin
          case (operation)
            OP_RESET: begin
              line_level_next = 1'b1;
              if (phase == 2'd0) begin
                countdown_next = timer_load(timing.reset_wait_time);
              end else begin
                countdown_next = '0;
                busy_flag_next = 1'b0;
              end
              phase_next = phase + 2'd1;
            end
            OP_WRITE, OP_READ: begin
              case (phase)
                2'd0: begin
                  line_level_next = 1'b0;
                  countdown_next  = timer_load(timing.low_pulse_time);
                  phase_next      = 2'd1;
                end
                2'd1: begin
                  if (operation == OP_WRITE) begin
                    line_level_next = send_byte[bit_count[2:0]];
                    bit_count_next  = bit_count + 4'd1;
                    countdown_next  = timer_load(timing.slot_time);
                  end else begin
                    line_level_next = 1'b1;
                    countdown_next  = timer_load(timing.sample_delay);
                  end
                  phase_next = 2'd2;
                end
                2'd2: begin
                  if (operation == OP_WRITE) begin
                    line_level_next = 1'b1;
                    countdown_next  = timer_load(timing.low_pulse_time);
                  end else begin
                    if (line_sample) received_byte_next[bit_count[2:0]] = 1'b1;
                    bit_count_next = bit_count + 4'd1;
                    countdown_next = timer_load(timing.slot_time);
                  end
                  phase_next = 2'd0;
                  // last bit: go idle at once, remaining slot time dropped
                  if (bit_count_next >= 4'(BITS_PER_TRANSFER)) begin
                    countdown_next = '0;
                    busy_flag_next = 1'b0;
                  end
                end
                default: phase_next = 2'd0;  // unused phase, no action
              endcase
            end
            default: begin
              countdown_next = '0;
              busy_flag_next = 1'b0;
            end
          endcase
        end
      end
    end else if (!busy_flag) begin
      busy_flag_next = 1'b1;
      phase_next     = 2'd0;
      case (mode)
        MODE_RESET: begin
          operation_next  = OP_RESET;
          line_level_next = 1'b0;
          countdown_next  = timer_load(timing.reset_low_time);
        end
        MODE_WRITE: begin
          operation_next = OP_WRITE;
          send_byte_next = write_byte;
          bit_count_next = 4'd0;
          countdown_next = timer_load(timing.start_delay);
        end
        default: begin
          operation_next     = OP_READ;
          bit_count_next     = 4'd0;
          received_byte_next = 8'd0;
          countdown_next     = timer_load(timing.start_delay);
        end
      endcase
    end
  end

  assign result.line_release = line_level_next;
  assign result.busy_res     = busy_flag_next;
  assign result.read_byte    = received_byte_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_flag     <= 1'b0;
      operation     <= OP_IDLE;
      phase         <= 2'd0;
      bit_count     <= 4'd0;
      send_byte     <= 8'd0;
      received_byte <= 8'd0;
      countdown     <= '0;
      line_level    <= 1'b1;
    end else if (step) begin
      busy_flag     <= busy_flag_next;
      operation     <= operation_next;
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      send_byte     <= send_byte_next;
      received_byte <= received_byte_next;
      countdown     <= countdown_next;
      line_level    <= line_level_next;
    end
  end

endmodule

// ----- src/one_wire_bus_master_core.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_core - 1-wire bus master driven by timer ticks
// Reset pulse, byte write and byte read, timed from programmable registers.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Beat contents
// s_*       in   s_tvalid/s_tready  tuser: mode; tdata: write_byte, line_sample
// m_*       out  m_tvalid/m_tready  tdata: line_release, busy_res, read_byte
// cfg_*     in   cfg_we             cfg_index selects timing register, cfg_data
//
// Every input beat yields exactly one output beat, and a beat can be taken every
// cycle while the skid is empty. Sequencer state loads at the accepting edge; the
// result loads the output register if free (offered from the next cycle), else the skid.
// A two-entry output stage (register plus skid) keeps s_tready registered:
// input stalls only when both entries hold results not yet taken.
// rst is synchronous: default timings restored, bus idle, line released.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [15:0]                           s_tdata,  // [7:0] write_byte, [8] line_sample
  input  logic [1:0]                            s_tuser,  // [1:0] mode
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [15:0]                           m_tdata,  // [0] line_release, [1] busy_res,
                                                          // [9:2] read_byte
  input  logic                                  cfg_we,
  input  logic [owbm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [owbm_pkg::CFG_BITS-1:0]         cfg_data
);
  import owbm_pkg::*;

  timing_t timing;
  res_t    result;
  res_t    out_res;
  res_t    skid_res;
  logic    skid_valid;
  logic    accept;
  logic    out_free;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.reset_low_time  <= RST_RESET_LOW;
      timing.reset_wait_time <= RST_RESET_WAIT;
      timing.start_delay     <= RST_START;
      timing.low_pulse_time  <= RST_LOW_PULSE;
      timing.sample_delay    <= RST_SAMPLE;
      timing.slot_time       <= RST_SLOT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:  timing.reset_low_time  <= cfg_data;
        REG_RESET_WAIT: timing.reset_wait_time <= cfg_data;
        REG_START:      timing.start_delay     <= cfg_data;
        REG_LOW_PULSE:  timing.low_pulse_time  <= cfg_data;
        REG_SAMPLE:     timing.sample_delay    <= cfg_data;
        REG_SLOT:       timing.slot_time       <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  owbm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .mode        (s_tuser),
    .write_byte  (s_tdata[7:0]),
    .line_sample (s_tdata[8]),
    .timing      (timing),
    .result      (result)
  );

  // output register and skid: control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      // skid drains first; no input is taken while it is full
      m_tvalid   <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // output register and skid: payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : result;
    end else if (accept) begin
      skid_res <= result;
    end
  end

  assign m_tdata = {6'd0, out_res.read_byte, out_res.busy_res, out_res.line_release};

endmodule

// ----- src/owbm_chk.sv -----
// ----------------------------------------------------------------------------
// owbm_chk - port checker for the 1-wire bus master
// Watches the stream ports and flags ordering or reset slips.
// ----------------------------------------------------------------------------
module owbm_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed under stall");

  // reset empties the output stage and opens the input
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output stage not empty after reset");

  // a beat accepted into an empty stage shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
    else $error("accepted beat gave no result");

  // bus is never left pulled low once idle
  a_idle_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[0])
    else $error("line held low while idle");

endmodule

bind one_wire_bus_master_core owbm_chk u_owbm_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/owbm_line_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_line_checker - result predictor and scoreboard for the 1-wire master
// Watches input, output and register write traffic, predicts the bus drive,
// busy flag and read byte for every input beat, compares output beats in order.
// ----------------------------------------------------------------------------
module owbm_line_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [15:0]                         s_tdata,  // [7:0] write_byte, [8] line_sample
  input  logic [1:0]                          s_tuser,  // [1:0] mode
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [15:0]                         m_tdata,  // [0] line_release, [1] busy_res,
                                                        // [9:2] read_byte
  input  logic                                cfg_we,
  input  logic [owbm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [owbm_pkg::CFG_BITS-1:0]       cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output logic                                model_busy
);
  import owbm_pkg::*;

  timing_t    tmg;
  op_t        op;
  logic [1:0] phase;
  logic [3:0] bit_n;
  logic [7:0] tx_byte;
  logic [7:0] rx_byte;
  timer_t     count;
  logic       line;
  res_t       line_state_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    model_busy = 1'b0;
  end

  function automatic timer_t ticks_for(input cfg_word_t v);
    timer_t t;
    t = v[TIMER_BITS-1:0];
    return (t == '0) ? timer_t'(1) : t;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic go_idle();
    count      = '0;
    model_busy = 1'b0;
  endtask

  // counter ran out on a tick: take the next step of the running operation
  task automatic phase_expired(input logic sample);
    if (op == OP_RESET) begin
      line = 1'b1;
      if (phase == 2'd0) count = ticks_for(tmg.reset_wait_time);
      else go_idle();
      phase = phase + 2'd1;
    end else if (op == OP_WRITE || op == OP_READ) begin
      case (phase)
        2'd0: begin
          line  = 1'b0;
          count = ticks_for(tmg.low_pulse_time);
        end
        2'd1: begin
          if (op == OP_WRITE) begin
            line  = tx_byte[bit_n[2:0]];
            bit_n = bit_n + 4'd1;
            count = ticks_for(tmg.slot_time);
          end else begin
            line  = 1'b1;
            count = ticks_for(tmg.sample_delay);
          end
        end
        2'd2: begin
          if (op == OP_WRITE) begin
            line  = 1'b1;
            count = ticks_for(tmg.low_pulse_time);
          end else begin
            if (sample) rx_byte[bit_n[2:0]] = 1'b1;
            bit_n = bit_n + 4'd1;
            count = ticks_for(tmg.slot_time);
          end
        end
        default: ;
      endcase
      if (phase == 2'd3) begin
        phase = 2'd0;
      end else begin
        phase = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
        // last bit: no trailing recovery or slot wait
        if (bit_n >= BITS_PER_TRANSFER && phase == 2'd0) go_idle();
      end
    end else begin
      go_idle();
    end
  endtask

  task automatic advance_sequencer(input logic [1:0] mode, input logic [7:0] wbyte,
                                   input logic sample);
    res_t r;
    if (mode == MODE_TICK) begin
      if (model_busy && count != '0) begin
        count = count - timer_t'(1);
        if (count == '0) phase_expired(sample);
      end
    end else if (!model_busy) begin
      model_busy = 1'b1;
      phase      = 2'd0;
      case (mode)
        MODE_RESET: begin
          op    = OP_RESET;
          line  = 1'b0;
          count = ticks_for(tmg.reset_low_time);
        end
        MODE_WRITE: begin
          op      = OP_WRITE;
          tx_byte = wbyte;
          bit_n   = '0;
          count   = ticks_for(tmg.start_delay);
        end
        default: begin
          op      = OP_READ;
          bit_n   = '0;
          rx_byte = '0;
          count   = ticks_for(tmg.start_delay);
        end
      endcase
    end
    r.line_release = line;
    r.busy_res     = model_busy;
    r.read_byte    = rx_byte;
    line_state_q.push_back(r);
  endtask

  task automatic write_timing(input logic [CFG_INDEX_BITS-1:0] idx, input cfg_word_t v);
    case (idx)
      REG_RESET_LOW:  tmg.reset_low_time  = v;
      REG_RESET_WAIT: tmg.reset_wait_time = v;
      REG_START:      tmg.start_delay     = v;
      REG_LOW_PULSE:  tmg.low_pulse_time  = v;
      REG_SAMPLE:     tmg.sample_delay    = v;
      REG_SLOT:       tmg.slot_time       = v;
      default: ;
    endcase
  endtask

  task automatic check_beat(input res_t got);
    res_t want;
    if (line_state_q.size() == 0) begin
      report_mismatch("unexpected output beat", int'(got), 0);
    end else begin
      want = line_state_q.pop_front();
      if (got.line_release !== want.line_release)
        report_mismatch("line_release", int'(got.line_release), int'(want.line_release));
      if (got.busy_res !== want.busy_res)
        report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
      if (got.read_byte !== want.read_byte)
        report_mismatch("read_byte", int'(got.read_byte), int'(want.read_byte));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tmg.reset_low_time  = RST_RESET_LOW;
      tmg.reset_wait_time = RST_RESET_WAIT;
      tmg.start_delay     = RST_START;
      tmg.low_pulse_time  = RST_LOW_PULSE;
      tmg.sample_delay    = RST_SAMPLE;
      tmg.slot_time       = RST_SLOT;
      op         = OP_IDLE;
      phase      = 2'd0;
      bit_n      = '0;
      tx_byte    = '0;
      rx_byte    = '0;
      count      = '0;
      line       = 1'b1;
      model_busy = 1'b0;
      line_state_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_beat(res_t'(m_tdata[9:0]));
      if (cfg_we) write_timing(cfg_index, cfg_data);
      if (s_tvalid && s_tready) advance_sequencer(s_tuser, s_tdata[7:0], s_tdata[8]);
    end
    pending = line_state_q.size();
  end

endmodule

// ----- tb/tb_one_wire_bus_master_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master_core - testbench top for the 1-wire bus master
// Drives command and tick beats with random gaps and output stalls, reprograms
// the timing registers between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master_core;
  import owbm_pkg::*;

  localparam int ITEM_TARGET  = 1650;
  localparam int PHASE_ITEMS  = 180;
  localparam int TAIL_CYCLES  = 8;   // output register plus skid, with margin
  // indexes past the last timing register: writes must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [15:0]               s_tdata   = '0;  // [7:0] write_byte, [8] line_sample
  logic [1:0]                s_tuser   = '0;  // [1:0] mode
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [15:0]               m_tdata;         // [0] line_release, [1] busy_res, [9:2] read_byte
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]       cfg_data  = '0;

  int   fail_count;
  int   pending;
  logic model_busy;

  int   beats_sent = 0;
  bit   calm       = 1'b0;  // no gaps or stalls while set
  bit   reset_ok   = 1'b1;  // which commands suit the current timings
  bit   byte_ok    = 1'b1;

  one_wire_bus_master_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  owbm_line_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending),
    .model_busy(model_busy)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: the normal run is well under a tenth of this
  initial begin
    #2_000_000;
    $display("one_wire_bus_master_core verification failed");
    $finish;
  end

  // output side: random stall before each beat is taken
  initial begin : sink
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  // one input beat; returns at the falling edge after acceptance
  task automatic send_beat(input logic [1:0] mode, input logic [7:0] wbyte,
                           input logic sample);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'd0, sample, wbyte};
    do @(posedge clk); while (s_tready !== 1'b1);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic tick(input logic sample);
    send_beat(MODE_TICK, 8'($urandom_range(0, 255)), sample);
  endtask

  // stop sending until every predicted result has been taken, then let the
  // output stage settle
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input cfg_word_t v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  function automatic logic [1:0] any_command();
    case ($urandom_range(0, 2))
      0:       return MODE_RESET;
      1:       return MODE_WRITE;
      default: return MODE_READ;
    endcase
  endfunction

  function automatic logic [1:0] pick_command();
    if (reset_ok && byte_ok) return any_command();
    if (reset_ok) return MODE_RESET;
    return ($urandom_range(0, 1) == 0) ? MODE_WRITE : MODE_READ;
  endfunction

  // Timing set per phase. Phase 0 is the minimum, phase 1 all zero (each
  // loads as one). Phases 2 and 3 hold full-scale values in the registers of
  // the operation that is then left alone, so the run stays short.
  task automatic program_timings(input int p);
    cfg_word_t rl, rw, sd, lp, sm, sl;
    reset_ok = 1'b1;
    byte_ok  = 1'b1;
    case (p)
      0: begin
        rl = 16'd1; rw = 16'd1; sd = 16'd1; lp = 16'd1; sm = 16'd1; sl = 16'd1;
      end
      1: begin
        rl = '0; rw = '0; sd = '0; lp = '0; sm = '0; sl = '0;
      end
      2: begin
        rl = cfg_word_t'($urandom_range(1, 6));
        rw = cfg_word_t'($urandom_range(1, 6));
        sd = 16'hFFFF; lp = 16'hFFFF; sm = 16'hFFFF; sl = 16'hFFFF;
        byte_ok = 1'b0;
      end
      3: begin
        rl = 16'hFFFF; rw = 16'hFFFF;
        sd = cfg_word_t'($urandom_range(1, 4));
        lp = cfg_word_t'($urandom_range(1, 4));
        sm = cfg_word_t'($urandom_range(1, 4));
        sl = cfg_word_t'($urandom_range(1, 4));
        reset_ok = 1'b0;
      end
      default: begin
        rl = cfg_word_t'($urandom_range(1, 10));
        rw = cfg_word_t'($urandom_range(1, 10));
        sd = cfg_word_t'($urandom_range(1, 6));
        lp = cfg_word_t'($urandom_range(1, 4));
        sm = cfg_word_t'($urandom_range(1, 4));
        sl = cfg_word_t'($urandom_range(1, 6));
        if ($urandom_range(0, 3) == 0) sl = cfg_word_t'($urandom_range(7, 40));
      end
    endcase
    write_reg(REG_RESET_LOW, rl);
    write_reg(REG_RESET_WAIT, rw);
    write_reg(REG_START, sd);
    write_reg(REG_LOW_PULSE, lp);
    write_reg(REG_SAMPLE, sm);
    write_reg(REG_SLOT, sl);
    // spare indexes get junk; a good block ignores it
    write_reg(REG_SPARE_LO, cfg_word_t'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_HI, (p % 2 == 0) ? 16'hFFFF : 16'h0000);
    cfg_we <= 1'b0;
  endtask

  // A command followed by ticks until the operation ends, with the odd
  // stray command landing while busy. Some runs open with idle ticks.
  task automatic run_op(input logic [1:0] mode);
    logic [7:0] wbyte;
    int         style;
    style = $urandom_range(0, 3);  // 0 all-high line, 1 all-low, else random
    case ($urandom_range(0, 3))
      0:       wbyte = 8'h00;
      1:       wbyte = 8'hFF;
      default: wbyte = 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4)) tick(1'($urandom_range(0, 1)));
    send_beat(mode, wbyte, 1'($urandom_range(0, 1)));
    while (model_busy) begin
      if ($urandom_range(0, 11) == 0)
        send_beat(any_command(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (style == 0)
        tick(1'b1);
      else if (style == 1)
        tick(1'b0);
      else
        tick(1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(0, 3)) tick(1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int p;
    int phase_end;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (p = 0; beats_sent < ITEM_TARGET; p++) begin
      hold_until_drained();
      program_timings(p);

      if (p == 0) begin
        // directed: ticks while idle, a reset pulse, commands while busy
        tick(1'b0);
        tick(1'b1);
        send_beat(MODE_RESET, 8'h00, 1'b0);
        send_beat(MODE_WRITE, 8'hFF, 1'b1);
        send_beat(MODE_READ, 8'h00, 1'b0);
        send_beat(MODE_RESET, 8'hFF, 1'b1);
        while (model_busy) tick(1'b0);
        tick(1'b1);
      end

      phase_end = beats_sent + PHASE_ITEMS;
      while (beats_sent < phase_end) begin
        calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 39) == 0) hold_until_drained();
        run_op(pick_command());
      end
    end

    hold_until_drained();
    if (fail_count == 0 && pending == 0)
      $display("one_wire_bus_master_core verification clean");
    else
      $display("one_wire_bus_master_core verification failed");
    $finish;
  end

endmodule

// ----- one_wire_bus_master_core.f -----
src/owbm_pkg.sv
src/owbm_seq.sv
src/one_wire_bus_master_core.sv
src/owbm_chk.sv
tb/owbm_line_checker.sv
tb/tb_one_wire_bus_master_core.sv
